/* src/rfp_pkg.sv */
// rfp_pkg: types and constants shared by the response frame parser
// item structs, frame position enum, status codes, header byte values
// no dependencies
`default_nettype none

package rfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_COMMAND = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DATA         = 8'd1;

  // frame byte values
  localparam logic [ByteW-1:0] PREAMBLE_BYTE  = 8'h00;
  localparam logic [ByteW-1:0] START_BYTE     = 8'hFF;
  localparam logic [ByteW-1:0] ERR_LEN_BYTE   = 8'h01;
  localparam logic [ByteW-1:0] ERR_LCS_BYTE   = 8'hFF;
  localparam logic [ByteW-1:0] ERR_TFI_BYTE   = 8'h7F;
  localparam logic [ByteW-1:0] HOST_TFI_BYTE  = 8'hD5;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_ID_MISMATCH  = 3'd2,
    ST_ERROR_FRAME  = 3'd3,
    ST_CMD_MISMATCH = 3'd4
  } status_t;

  // position inside the frame; idle also covers a finished frame
  typedef enum logic [3:0] {
    POS_IDLE  = 4'd0,
    POS_PRE0  = 4'd1,
    POS_PRE1  = 4'd2,
    POS_START = 4'd3,
    POS_LEN   = 4'd4,
    POS_LCS   = 4'd5,
    POS_TFI   = 4'd6,
    POS_CMD   = 4'd7,
    POS_DATA  = 4'd8
  } pos_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             read_start;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_data;
    status_t          status;
    logic [ByteW-1:0] data_count;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] expected_command;
    logic [ByteW-1:0] max_data;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* src/rfp_cfg_regs.sv */
// rfp_cfg_regs: configuration register file of the response frame parser
// depends on rfp_pkg
`default_nettype none

module rfp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr,
  input  wire logic [rfp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [rfp_pkg::ByteW-1:0]  cfg_data,
  output rfp_pkg::cfg_regs_t              cfg
);
  import rfp_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;

  // decode write index, other indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_EXPECTED_COMMAND: cfg_nxt.expected_command = cfg_data;
        CFG_MAX_DATA:         cfg_nxt.max_data         = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_command <= '0;
      cfg_r.max_data         <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/rfp_deframe.sv */
// rfp_deframe: frame position state machine and per-byte result decode
// depends on rfp_pkg
`default_nettype none

module rfp_deframe #(
  parameter int unsigned MAX_DATA = 255
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  rfp_pkg::in_item_t        item,
  input  rfp_pkg::cfg_regs_t       cfg,
  output logic                     res_valid,
  output rfp_pkg::out_item_t       res
);
  import rfp_pkg::*;

  localparam logic [ByteW-1:0] MaxDataC = ByteW'(MAX_DATA);

  pos_t             pos_r, pos_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] lcs_r, lcs_nxt;
  logic [ByteW-1:0] remain_r, remain_nxt;
  logic [ByteW-1:0] deliv_r, deliv_nxt;

  logic [ByteW-1:0] want_cmd;
  logic [ByteW-1:0] limit;
  logic [ByteW-1:0] len_count;
  logic [ByteW-1:0] pay_count;

  // payload count fixed at the command byte
  assign want_cmd  = cfg.expected_command + 8'd1;
  assign limit     = (cfg.max_data > MaxDataC) ? MaxDataC : cfg.max_data;
  assign len_count = (len_r >= 8'd2) ? (len_r - 8'd2) : '0;
  assign pay_count = (len_count > limit) ? limit : len_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_IDLE;
      len_r    <= '0;
      lcs_r    <= '0;
      remain_r <= '0;
      deliv_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      lcs_r    <= lcs_nxt;
      remain_r <= remain_nxt;
      deliv_r  <= deliv_nxt;
    end
  end

  // next position and result for one item
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    lcs_nxt    = lcs_r;
    remain_nxt = remain_r;
    deliv_nxt  = deliv_r;
    res_valid  = 1'b0;
    res        = '{data_byte: '0, is_data: 1'b0, status: ST_OK,
                   data_count: '0, frame_last: 1'b1};
    if (step) begin
      if (item.read_start) begin
        // ready byte of a new read, any unfinished frame is dropped
        pos_nxt    = POS_PRE0;
        len_nxt    = '0;
        lcs_nxt    = '0;
        remain_nxt = '0;
        deliv_nxt  = '0;
      end else begin
        case (pos_r)
          POS_PRE0, POS_PRE1: begin
            if (item.rx_byte != PREAMBLE_BYTE) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_HEADER;
              pos_nxt    = POS_IDLE;
            end else begin
              pos_nxt = (pos_r == POS_PRE0) ? POS_PRE1 : POS_START;
            end
          end
          POS_START: begin
            if (item.rx_byte != START_BYTE) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_HEADER;
              pos_nxt    = POS_IDLE;
            end else begin
              pos_nxt = POS_LEN;
            end
          end
          POS_LEN: begin
            len_nxt = item.rx_byte;
            pos_nxt = POS_LCS;
          end
          POS_LCS: begin
            lcs_nxt = item.rx_byte;
            pos_nxt = POS_TFI;
          end
          POS_TFI: begin
            if (item.rx_byte != HOST_TFI_BYTE) begin
              res_valid = 1'b1;
              pos_nxt   = POS_IDLE;
              if (len_r == ERR_LEN_BYTE && lcs_r == ERR_LCS_BYTE &&
                  item.rx_byte == ERR_TFI_BYTE) begin
                res.status = ST_ERROR_FRAME;
              end else begin
                res.status = ST_ID_MISMATCH;
              end
            end else begin
              pos_nxt = POS_CMD;
            end
          end
          POS_CMD: begin
            if (item.rx_byte != want_cmd) begin
              res_valid  = 1'b1;
              res.status = ST_CMD_MISMATCH;
              pos_nxt    = POS_IDLE;
            end else if (pay_count == '0) begin
              // empty payload ends the frame with an ok status
              res_valid = 1'b1;
              pos_nxt   = POS_IDLE;
            end else begin
              remain_nxt = pay_count;
              pos_nxt    = POS_DATA;
            end
          end
          POS_DATA: begin
            deliv_nxt      = deliv_r + 8'd1;
            remain_nxt     = remain_r - 8'd1;
            res_valid      = 1'b1;
            res.data_byte  = item.rx_byte;
            res.is_data    = 1'b1;
            res.data_count = deliv_r + 8'd1;
            res.frame_last = (remain_r == 8'd1);
            if (remain_r == 8'd1) begin
              pos_nxt = POS_IDLE;
            end
          end
          default: begin
            pos_nxt = POS_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* src/response_frame_parser.sv */
// response_frame_parser: top level, input register, deframer and result register
// depends on rfp_pkg, rfp_cfg_regs, rfp_deframe
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_data   (rx_byte, read_start)
//   out_    | output    | out_valid / out_ready | out_data  (data_byte .. frame_last)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while the output is not stalled; an item's result passes
// through the input register, then the result register
// synchronous active-low reset clears both valid flags, the frame state and
// the registers (expected_command 0, max_data 255); cfg_ready is always high
// a stalled output holds the result register; the input register fills and
// in_ready drops only when both registers are occupied and out_ready is low
`default_nettype none

module response_frame_parser #(
  parameter int unsigned MAX_DATA = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  rfp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rfp_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rfp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [rfp_pkg::ByteW-1:0]   cfg_data
);
  import rfp_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  cfg_regs_t cfg;

  assign cfg_ready = 1'b1;

  rfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage handshake: input register moves on when the result slot is free
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  rfp_deframe #(
    .MAX_DATA (MAX_DATA)
  ) u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // valid flags of both registers
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (advance && res_valid) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

/* bench/tb_response_frame_parser.sv */
// tb_response_frame_parser: self-checking bench for the response frame parser
// drives framed byte reads with random idling and checks every result item
// depends on rfp_pkg and response_frame_parser
`timescale 1ns / 100ps

module tb_response_frame_parser;
  import rfp_pkg::*;

  // expected results of the deframer, predicted per accepted item
  class frame_checker;
    logic [ByteW-1:0] want_cmd;
    logic [ByteW-1:0] max_bytes;
    int unsigned      byte_cap;

    // frame progress
    pos_t             pos;
    logic [ByteW-1:0] len_byte;
    logic [ByteW-1:0] lcs_byte;
    logic [ByteW-1:0] left;
    logic [ByteW-1:0] delivered;
    bit               done;

    out_item_t   awaited_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new(int unsigned cap);
      byte_cap   = cap;
      want_cmd   = 8'h00;
      max_bytes  = 8'hFF;
      mismatches = 0;
      checked    = 0;
      clear_frame();
      pos        = POS_IDLE;
      done       = 1'b1;
    endfunction

    function void clear_frame();
      len_byte  = '0;
      lcs_byte  = '0;
      left      = '0;
      delivered = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      if (idx == CFG_EXPECTED_COMMAND) begin
        want_cmd = val;
      end else if (idx == CFG_MAX_DATA) begin
        max_bytes = val;
      end
    endfunction

    function void add_result(logic [ByteW-1:0] data, logic is_data, status_t st,
                             logic [ByteW-1:0] count, logic last);
      out_item_t e;
      e.data_byte  = data;
      e.is_data    = is_data;
      e.status     = st;
      e.data_count = count;
      e.frame_last = last;
      awaited_results.push_back(e);
    endfunction

    function void fail_frame(status_t st);
      done = 1'b1;
      add_result('0, 1'b0, st, '0, 1'b1);
    endfunction

    // returns 1 when the item advanced a frame, 0 when it was ignored
    function bit take_rx_item(in_item_t it);
      logic [ByteW-1:0] b;
      int unsigned      count;
      int unsigned      limit;
      b = it.rx_byte;
      if (it.read_start) begin
        clear_frame();
        pos  = POS_PRE0;
        done = 1'b0;
        return 1'b1;
      end
      if (done) return 1'b0;
      case (pos)
        POS_PRE0, POS_PRE1: begin
          if (b != PREAMBLE_BYTE) fail_frame(ST_BAD_HEADER);
          else pos = (pos == POS_PRE0) ? POS_PRE1 : POS_START;
        end
        POS_START: begin
          if (b != START_BYTE) fail_frame(ST_BAD_HEADER);
          else pos = POS_LEN;
        end
        POS_LEN: begin
          len_byte = b;
          pos      = POS_LCS;
        end
        POS_LCS: begin
          lcs_byte = b;
          pos      = POS_TFI;
        end
        POS_TFI: begin
          if (b != HOST_TFI_BYTE) begin
            if (len_byte == ERR_LEN_BYTE && lcs_byte == ERR_LCS_BYTE &&
                b == ERR_TFI_BYTE)
              fail_frame(ST_ERROR_FRAME);
            else
              fail_frame(ST_ID_MISMATCH);
          end else begin
            pos = POS_CMD;
          end
        end
        POS_CMD: begin
          if (b != 8'(want_cmd + 8'd1)) begin
            fail_frame(ST_CMD_MISMATCH);
          end else begin
            // payload count fixed here from LEN and the byte limit
            count = (len_byte >= 8'd2) ? int'(len_byte) - 2 : 0;
            limit = (max_bytes > byte_cap) ? byte_cap : max_bytes;
            if (count > limit) count = limit;
            if (count == 0) begin
              done = 1'b1;
              add_result('0, 1'b0, ST_OK, '0, 1'b1);
            end else begin
              left = 8'(count);
              pos  = POS_DATA;
            end
          end
        end
        POS_DATA: begin
          delivered = delivered + 8'd1;
          left      = left - 8'd1;
          if (left == 0) done = 1'b1;
          add_result(b, 1'b1, ST_OK, delivered, left == 0);
        end
        default: done = 1'b1;
      endcase
      return 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_parser_result(out_item_t got);
      out_item_t e;
      checked++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing awaited: data %02h is_data %0d status %0d",
                         got.data_byte, got.is_data, got.status));
        return;
      end
      e = awaited_results.pop_front();
      if (got.data_byte !== e.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, e.data_byte));
      if (got.is_data !== e.is_data)
        report($sformatf("is_data %0d, want %0d", got.is_data, e.is_data));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.data_count !== e.data_count)
        report($sformatf("data_count %0d, want %0d", got.data_count, e.data_count));
      if (got.frame_last !== e.frame_last)
        report($sformatf("frame_last %0d, want %0d", got.frame_last, e.frame_last));
    endtask

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    task check_leftover();
      if (awaited_results.size() != 0)
        report($sformatf("%0d awaited results never arrived", awaited_results.size()));
    endtask
  endclass

  localparam int unsigned MAX_DATA_P    = 255;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 8'd2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  frame_checker fc;
  in_item_t     byte_q[$];
  logic [ByteW-1:0] cur_cmd;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_items;
  int unsigned live_items;
  int unsigned frames;
  int unsigned settings;

  response_frame_parser #(
    .MAX_DATA(MAX_DATA_P)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still awaited", cycle_count, fc.pending());
    $display("Regression FAIL");
    $finish;
  end

  // result side ready, with random stalls and a counted hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      fc.check_parser_result(out_data);
  end

  function automatic void add_byte(logic [ByteW-1:0] b, logic start);
    in_item_t it;
    it.rx_byte    = b;
    it.read_start = start;
    byte_q.push_back(it);
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (fc.take_rx_item(it)) live_items++;
    rx_items++;
    @(negedge clk);
  endtask

  task automatic send_queue();
    foreach (byte_q[i]) send_item(byte_q[i]);
    byte_q.delete();
    frames++;
  endtask

  task automatic wait_results();
    while (fc.pending() != 0) @(negedge clk);
  endtask

  // block idle: nothing awaited and the pipeline flushed
  task automatic wait_drain();
    in_valid = 1'b0;
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    fc.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idle(int unsigned s_pct, int unsigned r_pct, bit hold);
    @(posedge clk);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    hold_req       = hold;
    @(negedge clk);
  endtask

  // one read: mostly well-formed frames, some broken, truncated or noisy
  task automatic build_random_frame();
    int unsigned      kind;
    int unsigned      sel;
    int unsigned      len;
    int unsigned      cut;
    int unsigned      hdr_bad;
    logic [ByteW-1:0] len_b;
    logic [ByteW-1:0] lcs_b;
    logic [ByteW-1:0] id_b;
    logic [ByteW-1:0] cmd_b;
    logic [ByteW-1:0] good_cmd;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] hdr [3];
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (sel < 75) len = $urandom_range(0, 10);
    else if (sel < 96) len = $urandom_range(11, 40);
    else len = $urandom_range(41, 255);
    len_b    = 8'(len);
    lcs_b    = ($urandom_range(0, 99) < 85) ? 8'(256 - len) : 8'($urandom);
    good_cmd = cur_cmd + 8'd1;
    hdr[0]   = PREAMBLE_BYTE;
    hdr[1]   = PREAMBLE_BYTE;
    hdr[2]   = START_BYTE;
    hdr_bad  = (kind < 8) ? $urandom_range(0, 2) : 3;

    // stray bytes ahead of the read
    if ($urandom_range(0, 99) < 6)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom), 1'b0);
    add_byte(8'($urandom), 1'b1);
    for (int i = 0; i < 3 && i <= hdr_bad; i++) begin
      if (i == hdr_bad) begin
        do b = 8'($urandom); while (b == hdr[i]);
        add_byte(b, 1'b0);
      end else begin
        add_byte(hdr[i], 1'b0);
      end
    end

    if (hdr_bad == 3) begin
      if (kind < 14) begin
        // error frame
        add_byte(ERR_LEN_BYTE, 1'b0);
        add_byte(ERR_LCS_BYTE, 1'b0);
        add_byte(ERR_TFI_BYTE, 1'b0);
      end else if (kind < 20) begin
        // wrong identifier, sometimes behind an error-frame length pair
        if ($urandom_range(0, 1) == 1) begin
          len_b = ERR_LEN_BYTE;
          lcs_b = ERR_LCS_BYTE;
        end
        do id_b = 8'($urandom);
        while (id_b == HOST_TFI_BYTE ||
               (id_b == ERR_TFI_BYTE && len_b == ERR_LEN_BYTE && lcs_b == ERR_LCS_BYTE));
        add_byte(len_b, 1'b0);
        add_byte(lcs_b, 1'b0);
        add_byte(id_b, 1'b0);
      end else begin
        add_byte(len_b, 1'b0);
        add_byte(lcs_b, 1'b0);
        add_byte(HOST_TFI_BYTE, 1'b0);
        if (kind < 26) begin
          do cmd_b = 8'($urandom); while (cmd_b == good_cmd);
          add_byte(cmd_b, 1'b0);
        end else begin
          add_byte(good_cmd, 1'b0);
          repeat ((len >= 2) ? len - 2 : 0) add_byte(8'($urandom), 1'b0);
          // checksum and postamble
          add_byte(8'($urandom), 1'b0);
          add_byte(PREAMBLE_BYTE, 1'b0);
        end
      end
    end

    // read cut short, dropped by the next read start
    if ($urandom_range(0, 99) < 8 && byte_q.size() > 2) begin
      cut = $urandom_range(1, byte_q.size() - 1);
      while (byte_q.size() > cut) void'(byte_q.pop_back());
    end
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom), 1'b0);
  endtask

  task automatic run_phase(logic [ByteW-1:0] cmd, logic [ByteW-1:0] maxd,
                           int unsigned s_pct, int unsigned r_pct, bit hold);
    int unsigned stop_at;
    wait_drain();
    write_reg(CFG_EXPECTED_COMMAND, cmd);
    write_reg(CFG_MAX_DATA, maxd);
    cur_cmd = cmd;
    settings++;
    set_idle(s_pct, r_pct, hold);
    stop_at = live_items + PHASE_ITEMS;
    while (live_items < stop_at) begin
      build_random_frame();
      send_queue();
      // occasional pause until the output has caught up
      if ($urandom_range(0, 99) < 4) begin
        in_valid = 1'b0;
        wait_results();
      end
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    rst_n          = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_items       = 0;
    live_items     = 0;
    frames         = 0;
    settings       = 1;
    cur_cmd        = 8'h00;
    fc             = new(MAX_DATA_P);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed reads under reset settings
    add_byte(8'hA5, 1'b0);
    // one payload byte, trailer ignored
    add_byte(8'h01, 1'b1);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(START_BYTE, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'hFD, 1'b0);
    add_byte(HOST_TFI_BYTE, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    // new read in the middle of a frame
    add_byte(8'hFF, 1'b1);
    add_byte(PREAMBLE_BYTE, 1'b0);
    // error frame
    add_byte(8'h00, 1'b1);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(START_BYTE, 1'b0);
    add_byte(ERR_LEN_BYTE, 1'b0);
    add_byte(ERR_LCS_BYTE, 1'b0);
    add_byte(ERR_TFI_BYTE, 1'b0);
    // bad start byte
    add_byte(8'h80, 1'b1);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(8'h00, 1'b0);
    // zero length, empty payload
    add_byte(8'h7E, 1'b1);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(PREAMBLE_BYTE, 1'b0);
    add_byte(START_BYTE, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(HOST_TFI_BYTE, 1'b0);
    add_byte(8'h01, 1'b0);
    send_queue();

    // write to an index with no register behind it
    wait_drain();
    write_reg(CFG_UNUSED_IDX, 8'($urandom));

    // random phases over settings and idling
    run_phase(8'h00, 8'hFF, 0, 0, 1'b0);
    run_phase(8'hFF, 8'h00, 72, 0, 1'b0);
    run_phase(8'h4A, 8'h01, 0, 72, 1'b0);
    run_phase(8'($urandom), 8'($urandom_range(2, 8)), 26, 26, 1'b0);
    run_phase(8'($urandom), 8'hFF, 0, 0, 1'b1);
    run_phase(8'h80, 8'hFE, 26, 26, 1'b0);

    wait_drain();
    fc.check_leftover();
    $display("covered %0d reads, %0d items (%0d in frames), %0d results checked",
             frames, rx_items, live_items, fc.checked);
    $display("%0d register settings, idle and stalled sides, one long output hold-off",
             settings);
    if (fc.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fc.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
